[hw/rtl/pidtw_pkg.sv]
`default_nettype none

package pidtw_pkg;

    // Tuner phases, as reported in the tune_phase field.
    typedef enum logic [2:0] {
        PH_INIT    = 3'd0,
        PH_EVAL    = 3'd1,
        PH_STEPUP  = 3'd2,
        PH_RUN     = 3'd3,
        PH_COMPARE = 3'd4,
        PH_END     = 3'd5,
        PH_STOP    = 3'd6
    } t_phase;

    // Configuration register indexes.
    localparam logic [2:0] CFG_INITIAL_KP     = 3'd0;
    localparam logic [2:0] CFG_INITIAL_KI     = 3'd1;
    localparam logic [2:0] CFG_INITIAL_KD     = 3'd2;
    localparam logic [2:0] CFG_STEP_TOLERANCE = 3'd3;
    localparam logic [2:0] CFG_WINDOW_LIMIT   = 3'd4;

    // Configuration reset values.
    localparam logic [30:0] RST_INITIAL_KP     = 31'd1677722;
    localparam logic [30:0] RST_INITIAL_KI     = 31'd1678;
    localparam logic [30:0] RST_INITIAL_KD     = 31'd16777216;
    localparam logic [30:0] RST_STEP_TOLERANCE = 31'd167772;
    localparam logic [7:0]  RST_WINDOW_LIMIT   = 8'd20;

    // floor(x / 10) for any 32 bit x is (x * ceil(2^35 / 10)) >> 35.
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

    localparam logic [30:0]        STEP_MAX  = 31'h7FFF_FFFF;
    localparam logic signed [31:0] S32_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;

    typedef logic signed [31:0] t_gain;
    typedef logic [30:0]        t_step;

    function automatic logic [28:0] div10(input logic [31:0] x);
        logic [63:0] prod;
        prod = {32'd0, x} * {32'd0, DIV10_RECIP};
        return prod[63:35];
    endfunction

    // Saturate a 34 bit signed value to the signed 32 bit range.
    function automatic t_gain sat32(input logic signed [33:0] v);
        t_gain res;
        if (v > 34'(S32_MAX)) begin
            res = S32_MAX;
        end else if (v < 34'(S32_MIN)) begin
            res = S32_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/pid_with_twiddle_autotune_core.sv]
`default_nettype none
// The tuner takes one transition per accepted item, and its result passes the stages below.
// Throughput: one item per cycle while the master side is ready.
// The input register, product, sum and output stages each hold an item and drain on their own.
// Reset (i_rst_n low at a clock edge) loads the default configuration, restarts the
// tuner in its init phase, clears the integral and the previous sample and empties the pipe.

module pid_with_twiddle_autotune_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream: tdata = error_sample[15:0] (signed Q8.8).
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,
    // Result stream: tdata = drive[31:0], tune_phase[34:32], tuning_done[35], zero[39:36].
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,
    // Configuration write port.
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [30:0] i_cfg_wdata
);

    // Configuration registers.
    logic [30:0] r_init_gain [3];
    logic [30:0] r_step_tol;
    logic [7:0]  r_win_limit;

    // Tuner state. Gains, steps and the window length follow the configuration
    // while the tuner sits in its init phase, so a restart only has to reset
    // the phase and the control fields.
    pidtw_pkg::t_gain  r_gain [3];
    pidtw_pkg::t_gain  n_gain [3];
    pidtw_pkg::t_step  r_step [3];
    pidtw_pkg::t_step  n_step [3];
    logic [7:0]        r_wlen, n_wlen;
    logic [7:0]        r_cnt, n_cnt;
    logic [47:0]       r_wsum, n_wsum;
    logic [47:0]       r_best, n_best;
    logic [47:0]       r_latest, n_latest;
    pidtw_pkg::t_phase r_phase, n_phase;
    logic              r_ccf, n_ccf;
    logic              r_first, n_first;
    logic [1:0]        r_gidx, n_gidx;

    // One tenth of the selected step, taken from the previous cycle's state.
    // A step is only rescaled in compare or in a run window close, and the item
    // before either of those never changes the index or the step, so this
    // quotient is always current when it is used.
    logic [27:0]       r_q;

    logic signed [31:0] r_integ, n_integ;
    logic signed [15:0] r_last;

    // Pipeline.
    logic               r_v1, r_v2, r_v3, r_v4;
    logic               en1, en2, en3, en4;
    logic signed [15:0] r1_e;
    logic signed [31:0] r1_integ;
    logic signed [16:0] r1_d;
    pidtw_pkg::t_gain   r1_gain [3];
    pidtw_pkg::t_phase  r1_phase;
    logic signed [47:0] r2_p0;
    logic signed [63:0] r2_p1;
    logic signed [48:0] r2_p2;
    pidtw_pkg::t_phase  r2_phase;
    logic signed [63:0] r3_sum;
    pidtw_pkg::t_phase  r3_phase;
    logic signed [31:0] r4_drive;
    pidtw_pkg::t_phase  r4_phase;

    logic               accept;
    logic               restart;
    logic signed [15:0] e;
    logic signed [16:0] d;
    logic [30:0]        sq;
    logic [28:0]        init_step [3];

    assign e       = $signed(i_s_axis_tdata);
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign restart = i_cfg_wr_en && (i_cfg_index <= pidtw_pkg::CFG_WINDOW_LIMIT);

    // Each stage loads when it is empty or when the stage after it moves on.
    assign en4 = !r_v4 || i_m_axis_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_s_axis_tready = en1;

    always_comb begin
        logic signed [31:0] sq_full;
        sq_full = e * e;
        sq      = sq_full[30:0];
        d       = 17'(e) - 17'(r_last);
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            init_step[k] = pidtw_pkg::div10({1'b0, r_init_gain[k]} + 32'd5);
        end
    end

    // Tuner next state: one transition per accepted item.
    always_comb begin
        logic [1:0]          gi;
        logic [1:0]          gi_next;
        logic [1:0]          sel;
        logic [7:0]          cnt_inc;
        logic                closes;
        logic [47:0]         wsum_add;
        logic [32:0]         total;
        pidtw_pkg::t_gain    gain_sel;
        pidtw_pkg::t_step    step_sel;
        pidtw_pkg::t_gain    gain_up;
        pidtw_pkg::t_gain    gain_dn;
        logic [30:0]         rem;
        logic [31:0]         grow_sum;
        pidtw_pkg::t_step    grow;
        pidtw_pkg::t_step    shrink;

        gi       = (r_gidx == 2'd3) ? 2'd0 : r_gidx;
        gi_next  = r_first ? 2'd0 : ((gi == 2'd2) ? 2'd0 : gi + 2'd1);
        sel      = (r_phase == pidtw_pkg::PH_STEPUP) ? gi_next : gi;
        cnt_inc  = (r_cnt != 8'hFF) ? r_cnt + 8'd1 : r_cnt;
        closes   = cnt_inc >= r_wlen;
        wsum_add = r_wsum + {17'd0, sq};
        total    = {2'd0, r_step[0]} + {2'd0, r_step[1]} + {2'd0, r_step[2]};
        gain_sel = r_gain[sel];
        step_sel = r_step[sel];
        gain_up  = pidtw_pkg::sat32(34'(gain_sel) + 34'({1'b0, step_sel}));
        gain_dn  = pidtw_pkg::sat32(34'(gain_sel) - 34'({step_sel, 1'b0}));

        // Grow is s + floor((s + 5) / 10), shrink is s - floor((s + 4) / 10),
        // both from q = floor(s / 10) and the remainder s - 10q.
        rem      = step_sel - ({r_q, 3'd0} + {2'd0, r_q, 1'b0});
        grow_sum = {1'b0, step_sel} + {4'd0, r_q}
                   + {31'd0, (rem[3:0] >= 4'd5)};
        grow     = grow_sum[31] ? pidtw_pkg::STEP_MAX : grow_sum[30:0];
        shrink   = step_sel - {3'd0, r_q} - {30'd0, (rem[3:0] >= 4'd6)};

        for (int k = 0; k < 3; k++) begin
            n_gain[k] = r_gain[k];
            n_step[k] = r_step[k];
        end
        n_wlen   = r_wlen;
        n_cnt    = r_cnt;
        n_wsum   = r_wsum;
        n_best   = r_best;
        n_latest = r_latest;
        n_phase  = r_phase;
        n_ccf    = r_ccf;
        n_first  = r_first;
        n_gidx   = r_gidx;

        if (r_phase == pidtw_pkg::PH_INIT) begin
            for (int k = 0; k < 3; k++) begin
                n_gain[k] = {1'b0, r_init_gain[k]};
                n_step[k] = {2'd0, init_step[k]};
            end
            n_wlen = r_win_limit;
        end

        if (accept) begin
            n_cnt = cnt_inc;
            case (r_phase)
                pidtw_pkg::PH_INIT: begin
                    n_wsum = wsum_add;
                    if (closes) begin
                        n_cnt    = 8'd0;
                        n_best   = wsum_add;
                        n_latest = wsum_add;
                        n_wsum   = 48'd0;
                        n_phase  = pidtw_pkg::PH_EVAL;
                    end
                end
                pidtw_pkg::PH_EVAL: begin
                    n_phase = (total > {2'd0, r_step_tol}) ? pidtw_pkg::PH_STEPUP
                                                          : pidtw_pkg::PH_END;
                end
                pidtw_pkg::PH_STEPUP: begin
                    n_gidx      = gi_next;
                    n_gain[sel] = gain_up;
                    n_phase     = pidtw_pkg::PH_RUN;
                    n_cnt       = 8'd0;
                    n_ccf       = 1'b0;
                    // A full sweep over the three gains lengthens the window.
                    if (gi_next == 2'd0 && !r_first) begin
                        n_wlen = (r_wlen >= r_win_limit) ? r_win_limit : r_wlen + 8'd1;
                        if (total < {2'd0, r_step_tol}) begin
                            n_phase = pidtw_pkg::PH_END;
                        end
                    end
                    n_first = 1'b0;
                end
                pidtw_pkg::PH_RUN: begin
                    n_wsum = wsum_add;
                    if (closes) begin
                        n_latest = wsum_add;
                        n_wsum   = 48'd0;
                        if (!r_ccf) begin
                            n_phase = pidtw_pkg::PH_COMPARE;
                        end else begin
                            if (wsum_add < r_best) begin
                                n_best      = wsum_add;
                                n_step[sel] = grow;
                            end else begin
                                n_gain[sel] = gain_up;
                                n_step[sel] = shrink;
                            end
                            n_phase = pidtw_pkg::PH_STEPUP;
                        end
                    end
                end
                pidtw_pkg::PH_COMPARE: begin
                    if (r_latest < r_best) begin
                        n_best      = r_latest;
                        n_step[sel] = grow;
                        n_phase     = pidtw_pkg::PH_STEPUP;
                    end else begin
                        n_gain[sel] = gain_dn;
                        n_phase     = pidtw_pkg::PH_RUN;
                        n_cnt       = 8'd0;
                    end
                    n_ccf = 1'b1;
                end
                pidtw_pkg::PH_END: begin
                    n_phase = pidtw_pkg::PH_STOP;
                end
                default: begin
                end
            endcase
        end

        // A write to one of the five configuration registers restarts the tuner.
        if (restart) begin
            n_wsum   = 48'd0;
            n_best   = 48'd0;
            n_latest = 48'd0;
            n_phase  = pidtw_pkg::PH_INIT;
            n_ccf    = 1'b0;
            n_cnt    = 8'd0;
            n_first  = 1'b1;
            n_gidx   = 2'd0;
        end
    end

    always_comb begin
        n_integ = pidtw_pkg::sat32(34'(r_integ) + 34'(e));
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_gain[0] <= pidtw_pkg::RST_INITIAL_KP;
            r_init_gain[1] <= pidtw_pkg::RST_INITIAL_KI;
            r_init_gain[2] <= pidtw_pkg::RST_INITIAL_KD;
            r_step_tol     <= pidtw_pkg::RST_STEP_TOLERANCE;
            r_win_limit    <= pidtw_pkg::RST_WINDOW_LIMIT;
            r_cnt          <= 8'd0;
            r_wsum         <= 48'd0;
            r_best         <= 48'd0;
            r_latest       <= 48'd0;
            r_phase        <= pidtw_pkg::PH_INIT;
            r_ccf          <= 1'b0;
            r_first        <= 1'b1;
            r_gidx         <= 2'd0;
            r_integ        <= 32'sd0;
            r_last         <= 16'sd0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_v3           <= 1'b0;
            r_v4           <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    pidtw_pkg::CFG_INITIAL_KP:     r_init_gain[0] <= i_cfg_wdata;
                    pidtw_pkg::CFG_INITIAL_KI:     r_init_gain[1] <= i_cfg_wdata;
                    pidtw_pkg::CFG_INITIAL_KD:     r_init_gain[2] <= i_cfg_wdata;
                    pidtw_pkg::CFG_STEP_TOLERANCE: r_step_tol     <= i_cfg_wdata;
                    pidtw_pkg::CFG_WINDOW_LIMIT:   r_win_limit    <= i_cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
            r_cnt    <= n_cnt;
            r_wsum   <= n_wsum;
            r_best   <= n_best;
            r_latest <= n_latest;
            r_phase  <= n_phase;
            r_ccf    <= n_ccf;
            r_first  <= n_first;
            r_gidx   <= n_gidx;
            if (accept) begin
                r_integ <= n_integ;
                r_last  <= e;
            end
            if (en1) begin
                r_v1 <= accept;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Datapath registers: gains, steps and the pipeline payload.
    always_ff @(posedge i_clk) begin
        logic [1:0]  gi_q;
        logic [28:0] q_full;
        for (int k = 0; k < 3; k++) begin
            r_gain[k] <= n_gain[k];
            r_step[k] <= n_step[k];
        end
        r_wlen <= n_wlen;

        gi_q   = (r_gidx == 2'd3) ? 2'd0 : r_gidx;
        q_full = pidtw_pkg::div10({1'b0, r_step[gi_q]});
        r_q    <= q_full[27:0];

        // Stage 1: the sample, integral, difference and the gains after tuning.
        if (en1) begin
            r1_e     <= e;
            r1_integ <= n_integ;
            r1_d     <= d;
            for (int k = 0; k < 3; k++) begin
                r1_gain[k] <= n_gain[k];
            end
            r1_phase <= n_phase;
        end
        // Stage 2: the three products.
        if (en2) begin
            r2_p0    <= 48'(r1_gain[0]) * 48'(r1_e);
            r2_p1    <= 64'(r1_gain[1]) * 64'(r1_integ);
            r2_p2    <= 49'(r1_gain[2]) * 49'(r1_d);
            r2_phase <= r1_phase;
        end
        // Stage 3: exact sum of the PID terms.
        if (en3) begin
            r3_sum   <= 64'(r2_p0) + r2_p1 + 64'(r2_p2);
            r3_phase <= r2_phase;
        end
        // Stage 4: negate, round to Q16.16 and saturate.
        if (en4) begin
            r4_drive <= drive_sat;
            r4_phase <= r3_phase;
        end
    end

    logic signed [31:0] drive_sat;
    always_comb begin
        logic signed [64:0] neg_round;
        logic signed [48:0] shifted;
        neg_round = 65'sd32768 - 65'(r3_sum);
        shifted   = neg_round[64:16];
        if (shifted > 49'(pidtw_pkg::S32_MAX)) begin
            drive_sat = pidtw_pkg::S32_MAX;
        end else if (shifted < 49'(pidtw_pkg::S32_MIN)) begin
            drive_sat = pidtw_pkg::S32_MIN;
        end else begin
            drive_sat = shifted[31:0];
        end
    end

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = {4'd0,
                              (r4_phase == pidtw_pkg::PH_END) ||
                              (r4_phase == pidtw_pkg::PH_STOP),
                              r4_phase,
                              r4_drive};

    // The tuner only moves on an accepted item or a configuration write.
    a_phase_moves_on_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!accept && !i_cfg_wr_en) |=> $stable(r_phase))
        else $error("tuner phase changed without an item or a write");

    // Without a configuration write, a stopped tuner stays stopped with its gains frozen.
    a_stop_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pidtw_pkg::PH_STOP && !i_cfg_wr_en)
        |=> (r_phase == pidtw_pkg::PH_STOP) && $stable(r_gain[0])
            && $stable(r_gain[1]) && $stable(r_gain[2]))
        else $error("gains or phase changed after tuning stopped");

    // Input back-pressure only when every stage holds an item.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import pidtw_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned PIPE_SETTLE = 8;
    localparam int unsigned NUM_BATCHES = 10;
    localparam int unsigned LONG_HOLD = 100;

    // One expected result item: the drive value and the tuner status beside it.
    typedef struct packed {
        logic signed [31:0] drive;
        t_phase             phase;
        logic               done;
    } drive_result_t;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [15:0] i_s_axis_tdata = '0;
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = CFG_INITIAL_KP;
    logic [30:0] i_cfg_wdata = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [39:0] o_m_axis_tdata;

    pid_with_twiddle_autotune_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Error samples waiting to be offered, and drive results still owed by the block.
    logic [15:0]   samples_to_send[$];
    drive_result_t pending_drives[$];

    int unsigned send_idle_pct = 34;
    int unsigned recv_idle_pct = 70;
    bit          hold_request = 1'b0;
    int unsigned items_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned settings_written = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  phases_seen = '0;

    // ------------------------------------------------------------------
    // Predictor: a private copy of the configuration and of the tuner.
    // ------------------------------------------------------------------
    logic [30:0]        cfg_gain[3];
    logic [30:0]        cfg_tol;
    logic [7:0]         cfg_win;

    logic signed [31:0] tn_gain[3];
    logic [30:0]        tn_step[3];
    logic signed [31:0] err_integral;
    logic signed [15:0] prev_err;
    logic [47:0]        win_sum;
    logic [47:0]        best_score;
    logic [47:0]        latest_score;
    t_phase             tn_phase;
    logic               from_compare;
    logic [7:0]         smp_cnt;
    logic [7:0]         win_len;
    logic               first_pass;
    logic [1:0]         gain_sel;

    function automatic logic signed [31:0] clamp_s32(input longint v);
        logic signed [31:0] r;
        if (v > longint'(S32_MAX)) begin
            r = S32_MAX;
        end else if (v < longint'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Grow or shrink a step by num/10 with rounding, saturating at the step range.
    function automatic logic [30:0] scaled_step(input logic [30:0] s, input int unsigned num);
        logic [63:0] v;
        v = ({33'd0, s} * 64'(num) + 64'd5) / 64'd10;
        return (v > {33'd0, STEP_MAX}) ? STEP_MAX : v[30:0];
    endfunction

    function automatic logic [32:0] step_total();
        return 33'(tn_step[0]) + 33'(tn_step[1]) + 33'(tn_step[2]);
    endfunction

    function automatic longint step_as_long(input int k);
        return longint'({33'd0, tn_step[k]});
    endfunction

    function automatic void restart_tuner();
        for (int k = 0; k < 3; k++) begin
            tn_gain[k] = {1'b0, cfg_gain[k]};
            tn_step[k] = 31'(({1'b0, cfg_gain[k]} + 32'd5) / 32'd10);
        end
        win_sum      = '0;
        best_score   = '0;
        latest_score = '0;
        tn_phase     = PH_INIT;
        from_compare = 1'b0;
        smp_cnt      = '0;
        win_len      = cfg_win;
        first_pass   = 1'b1;
        gain_sel     = '0;
    endfunction

    // A register write reloads the tuner; indexes past the last register are ignored.
    function automatic void apply_setting(input logic [2:0] idx, input logic [30:0] val);
        case (idx)
            CFG_INITIAL_KP:     cfg_gain[0] = val;
            CFG_INITIAL_KI:     cfg_gain[1] = val;
            CFG_INITIAL_KD:     cfg_gain[2] = val;
            CFG_STEP_TOLERANCE: cfg_tol = val;
            CFG_WINDOW_LIMIT:   cfg_win = val[7:0];
            default:            return;
        endcase
        restart_tuner();
    endfunction

    // One transition of the twiddle state machine, fed with e*e of the new sample.
    function automatic void advance_tuner(input logic [47:0] sq);
        int gi;
        gi = (gain_sel < 2'd3) ? int'(gain_sel) : 0;
        if (smp_cnt < 8'd255) smp_cnt++;
        case (tn_phase)
            PH_INIT: begin
                win_sum = win_sum + sq;
                if (smp_cnt >= win_len) begin
                    smp_cnt      = '0;
                    best_score   = win_sum;
                    latest_score = win_sum;
                    win_sum      = '0;
                    tn_phase     = PH_EVAL;
                end
            end
            PH_EVAL: begin
                tn_phase = (step_total() > {2'b0, cfg_tol}) ? PH_STEPUP : PH_END;
            end
            PH_STEPUP: begin
                gi = first_pass ? 0 : (gi + 1) % 3;
                gain_sel = 2'(gi);
                tn_gain[gi] = clamp_s32(longint'(tn_gain[gi]) + step_as_long(gi));
                tn_phase = PH_RUN;
                smp_cnt = '0;
                from_compare = 1'b0;
                // A full sweep over the three gains lengthens the window and
                // may end the tuning; the nudge just made stays in place.
                if (gi == 0 && !first_pass) begin
                    if (win_len >= cfg_win) win_len = cfg_win;
                    else win_len++;
                    if (step_total() < {2'b0, cfg_tol}) tn_phase = PH_END;
                end
                first_pass = 1'b0;
            end
            PH_RUN: begin
                win_sum = win_sum + sq;
                if (smp_cnt >= win_len) begin
                    latest_score = win_sum;
                    win_sum = '0;
                    if (!from_compare) begin
                        tn_phase = PH_COMPARE;
                    end else begin
                        if (latest_score < best_score) begin
                            best_score = latest_score;
                            tn_step[gi] = scaled_step(tn_step[gi], 11);
                        end else begin
                            tn_gain[gi] = clamp_s32(longint'(tn_gain[gi]) + step_as_long(gi));
                            tn_step[gi] = scaled_step(tn_step[gi], 9);
                        end
                        tn_phase = PH_STEPUP;
                    end
                end
            end
            PH_COMPARE: begin
                if (latest_score < best_score) begin
                    best_score = latest_score;
                    tn_step[gi] = scaled_step(tn_step[gi], 11);
                    tn_phase = PH_STEPUP;
                end else begin
                    tn_gain[gi] = clamp_s32(longint'(tn_gain[gi]) - 2 * step_as_long(gi));
                    tn_phase = PH_RUN;
                    smp_cnt = '0;
                end
                from_compare = 1'b1;
            end
            PH_END: tn_phase = PH_STOP;
            default: ;
        endcase
    endfunction

    // Tune first, then run the PID law with the updated gains.
    function automatic drive_result_t compute_drive(input logic [15:0] raw);
        drive_result_t r;
        int            e;
        int            d;
        longint        acc;
        e = int'($signed(raw));
        d = e - int'(prev_err);
        advance_tuner(48'(longint'(e) * longint'(e)));
        err_integral = clamp_s32(longint'(err_integral) + longint'(e));
        prev_err = raw;
        acc = longint'(tn_gain[0]) * longint'(e) + longint'(tn_gain[1]) * longint'(err_integral)
            + longint'(tn_gain[2]) * longint'(d);
        acc = -acc;
        r.drive = clamp_s32((acc + 64'sd32768) >>> 16);
        r.phase = tn_phase;
        r.done  = (tn_phase == PH_END) || (tn_phase == PH_STOP);
        phases_seen[tn_phase] = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued samples, idling at random between items. The
    // prediction for an item is made at the edge where it is accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pending_drives.push_back(compute_drive(i_s_axis_tdata));
                items_accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= samples_to_send.pop_front();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stalls the result side at random, once for a long stretch
    // so that the pipe fills and the input side backs up, and checks every
    // accepted result against the oldest prediction.
    // ------------------------------------------------------------------
    int unsigned hold_left = 0;
    bit          hold_taken = 1'b0;

    always @(posedge i_clk) begin
        drive_result_t exp_r;
        logic [2:0]    act_phase;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                act_phase = o_m_axis_tdata[34:32];
                if (pending_drives.size() == 0) begin
                    $display("%0t: result with no item pending: drive %0d phase %0d done %0b",
                             $time, $signed(o_m_axis_tdata[31:0]), act_phase,
                             o_m_axis_tdata[35]);
                    error_count++;
                end else begin
                    exp_r = pending_drives.pop_front();
                    results_checked++;
                    if (o_m_axis_tdata[31:0] !== exp_r.drive) begin
                        $display("%0t: drive mismatch: expected %0d, got %0d", $time,
                                 exp_r.drive, $signed(o_m_axis_tdata[31:0]));
                        error_count++;
                    end
                    if (act_phase !== exp_r.phase) begin
                        $display("%0t: tune_phase mismatch: expected %0d, got %0d", $time,
                                 exp_r.phase, act_phase);
                        error_count++;
                    end
                    if (o_m_axis_tdata[35] !== exp_r.done) begin
                        $display("%0t: tuning_done mismatch: expected %0b, got %0b", $time,
                                 exp_r.done, o_m_axis_tdata[35]);
                        error_count++;
                    end
                end
            end
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles, %0d results outstanding",
                     $time, CYCLE_LIMIT, pending_drives.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Wait until every sample has been taken and every result has come back,
    // then let the pipe settle.
    task automatic settle();
        while (samples_to_send.size() != 0 || i_s_axis_tvalid || pending_drives.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [2:0] idx, input logic [30:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        apply_setting(idx, val);
        settings_written++;
    endtask

    // Writes all five registers; the window register gets junk above its byte at times.
    task automatic load_settings(input logic [30:0] kp, input logic [30:0] ki,
                                 input logic [30:0] kd, input logic [30:0] tol,
                                 input logic [7:0] win);
        logic [22:0] junk;
        junk = $urandom_range(0, 1) ? 23'($urandom()) : '0;
        write_setting(CFG_INITIAL_KP, kp);
        write_setting(CFG_INITIAL_KI, ki);
        write_setting(CFG_INITIAL_KD, kd);
        write_setting(CFG_STEP_TOLERANCE, tol);
        write_setting(CFG_WINDOW_LIMIT, {junk, win});
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly moderate gains, now and then anything in the 31 bit range.
    function automatic logic [30:0] pick_gain();
        logic [30:0] g;
        if ($urandom_range(0, 3) == 0) g = 31'($urandom());
        else g = 31'($urandom_range(0, 32'h0400_0000));
        return g;
    endfunction

    // Tolerance mostly under the step sum so tuning ends partway; else 0 or STEP_MAX.
    function automatic logic [30:0] pick_tolerance(input logic [30:0] kp, input logic [30:0] ki,
                                                   input logic [30:0] kd);
        longint total;
        logic [30:0] t;
        total = (longint'(kp) + 5) / 10 + (longint'(ki) + 5) / 10 + (longint'(kd) + 5) / 10;
        case ($urandom_range(0, 7))
            0:       t = '0;
            1:       t = STEP_MAX;
            default: t = 31'(total * longint'($urandom_range(60, 99)) / 100);
        endcase
        return t;
    endfunction

    // Full range samples mixed with scaled-down ones, so window scores both
    // improve and worsen.
    function automatic logic [15:0] pick_sample();
        logic signed [15:0] v;
        v = 16'($urandom());
        if ($urandom_range(0, 2) != 0) v = v >>> $urandom_range(0, 14);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        logic [30:0] kp;
        logic [30:0] ki;
        logic [30:0] kd;
        logic [30:0] tol;
        logic [7:0]  win;
        int unsigned n;

        cfg_gain[0]  = RST_INITIAL_KP;
        cfg_gain[1]  = RST_INITIAL_KI;
        cfg_gain[2]  = RST_INITIAL_KD;
        cfg_tol      = RST_STEP_TOLERANCE;
        cfg_win      = RST_WINDOW_LIMIT;
        err_integral = '0;
        prev_err     = '0;
        restart_tuner();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset settings: full-scale samples of both signs push the
        // integral and the derivative to their extremes.
        @(negedge i_clk);
        samples_to_send = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                            16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF};

        // Zero window with the largest gains and no tolerance: every window is one
        // sample, gain nudges saturate and the drive clips on both sides.
        settle();
        load_settings(STEP_MAX, STEP_MAX, STEP_MAX, '0, 8'd0);
        end_writes();
        @(negedge i_clk);
        samples_to_send = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                            16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF, 16'h8000};

        // Step sum exactly equal to the tolerance: evaluate must not go on, so
        // tuning ends at once and the gains stay frozen while the PID keeps running.
        settle();
        load_settings(31'd100, 31'd100, 31'd100, 31'd30, 8'd1);
        end_writes();
        @(negedge i_clk);
        repeat (6) samples_to_send.push_back(pick_sample());

        // Random part: batches under fresh settings, some batches only poke an
        // unused register index, which must leave the tuner where it was.
        for (int b = 0; b < NUM_BATCHES; b++) begin
            settle();
            if (b == 3 || b == 8) begin
                write_setting(CFG_WINDOW_LIMIT + 3'($urandom_range(1, 3)), 31'($urandom()));
            end else begin
                kp = pick_gain();
                ki = pick_gain();
                kd = pick_gain();
                if (b == 5) begin
                    kp = STEP_MAX;
                    ki = STEP_MAX;
                    kd = STEP_MAX;
                end
                win = 8'($urandom_range(1, 4));
                if (b == 2) win = 8'd0;
                if (b == 4) win = 8'd255;
                tol = pick_tolerance(kp, ki, kd);
                if (b == 6) tol = STEP_MAX;
                if (b == 9) tol = '0;
                load_settings(kp, ki, kd, tol, win);
            end
            end_writes();
            @(negedge i_clk);
            // First the sender idles a third of the time and the receiver most of it,
            // then the other way round, then neither side idles at all.
            if (b < 3) begin
                send_idle_pct = 34;
                recv_idle_pct = 70;
            end else if (b < 6) begin
                send_idle_pct = 70;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            n = $urandom_range(30, 50);
            repeat (n) samples_to_send.push_back(pick_sample());
            if (b == 7) hold_request = 1'b1;
        end

        settle();
        repeat (PIPE_SETTLE) @(posedge i_clk);
        if (pending_drives.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_drives.size());
            error_count++;
        end

        $display("Sent %0d error samples, checked %0d drive results, %0d register writes.",
                 items_accepted, results_checked, settings_written);
        $display("Tuner phases reached (bit n = phase n): %b, mismatches: %0d",
                 phases_seen, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/pidtw_pkg.sv
hw/rtl/pid_with_twiddle_autotune_core.sv
tb/tb.sv
